// File: design/assert_macros.svh
// Assertion macros used by the port-level checker of the rectangle block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define MAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define MAR_ASSERT_NEXT(label, ante, cons, msg) \
  `MAR_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: design/mar_pkg.sv
// Shared constants and controller/datapath interface types of the rectangle block.
// No dependencies.
package mar_pkg;

  localparam int unsigned MAX_COLS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF = 256;
  localparam int unsigned ROW_WIDTH_W  = 9;
  localparam int unsigned AREA_W       = 17;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(256);

  typedef struct packed {
    logic accept;
    logic update;
    logic read_top;
    logic pop;
    logic measure;
    logic push;
    logic emit;
    logic clear;
  } mar_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic drain;
    logic pop_cond;
    logic row_ends;
    logic last;
    logic out_busy;
    logic clear_done;
  } mar_sts_t;

endpackage

// File: design/maximal_all_ones_rectangle.sv
// Top level of the largest all-ones rectangle block: sequencer plus datapath.
// Depends on mar_pkg, mar_ctrl, mar_dp.
//
// Cells of a 0/1 matrix enter one per request in row-major order, with the row
// width set by the configuration register; the request flagged last returns the
// area of the largest all-ones rectangle, after which heights and maximum restart.
// Each cell passes through acceptance, update of its column height in the
// heights RAM, a stack check and the push, with a compare of the stack top
// when the index stack is not empty, plus a stack check, compare and pop for
// every column popped off the index stack, because each pop reads the heights
// RAM and the stack RAM in turn; the end of a row adds a final stack check.
// After the last cell the block emits the result, waiting while an earlier
// result is still stalled, and then clears the heights RAM one entry a cycle,
// up to the highest column used; after reset that pass clears all MAX_COLS.
// Input is stalled during that pass; configuration writes are taken at any time.
module maximal_all_ones_rectangle #(
  parameter int unsigned MAX_COLS = mar_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = mar_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mar_pkg::ROW_WIDTH_W-1:0] cfg_row_width_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cell_req_i,
  input  logic                            last_cell_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mar_pkg::AREA_W-1:0]      max_area_o
);

  import mar_pkg::*;

  mar_cmd_t cmd;
  mar_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mar_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mar_dp #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_row_width_i(cfg_row_width_i),
    .cell_req_i     (cell_req_i),
    .last_cell_i    (last_cell_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .max_area_o     (max_area_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// File: design/mar_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mar_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [DataW-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [DataW-1:0]                           rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/mar_ctrl.sv
// Sequencer of the rectangle block: steps the datapath through update, stack scan,
// drain, result and clearing pass. Depends on mar_pkg.
module mar_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mar_pkg::mar_sts_t  sts_i,
  output mar_pkg::mar_cmd_t  cmd_o
);

  import mar_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StUpd   = 3'd1;
  localparam logic [2:0] StCmpRd = 3'd2;
  localparam logic [2:0] StCmp   = 3'd3;
  localparam logic [2:0] StPop   = 3'd4;
  localparam logic [2:0] StPush  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;
  localparam logic [2:0] StClr   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d      = StCmpRd;
      end
      StCmpRd: begin
        if (!sts_i.stack_empty) begin
          cmd_o.read_top = 1'b1;
          state_d        = StCmp;
        end else if (!sts_i.drain) begin
          state_d = StPush;
        end else if (sts_i.last) begin
          state_d = StOut;
        end else begin
          state_d = StIdle;
        end
      end
      StCmp: begin
        if (sts_i.pop_cond) begin
          cmd_o.pop = 1'b1;
          state_d   = StPop;
        end else begin
          state_d = StPush;
        end
      end
      StPop: begin
        cmd_o.measure = 1'b1;
        state_d       = StCmpRd;
      end
      StPush: begin
        cmd_o.push = 1'b1;
        state_d    = sts_i.row_ends ? StCmpRd : StIdle;
      end
      StOut: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = StClr;
        end
      end
      StClr: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/mar_dp.sv
// Datapath of the rectangle block: column heights memory, index stack memory,
// area multiplier, running maximum and output register. Depends on mar_pkg, mar_ram.
module mar_dp #(
  parameter int unsigned MAX_COLS = mar_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = mar_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [mar_pkg::ROW_WIDTH_W-1:0] cfg_row_width_i,
  input  logic                            cell_req_i,
  input  logic                            last_cell_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [mar_pkg::AREA_W-1:0]      max_area_o,
  input  mar_pkg::mar_cmd_t               cmd_i,
  output mar_pkg::mar_sts_t               sts_o
);

  import mar_pkg::*;

  localparam int unsigned IW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW1 = $clog2(MAX_COLS + 1);
  localparam int unsigned HW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW  = HW + CW1;
  localparam int unsigned WW  = (CW1 > ROW_WIDTH_W) ? CW1 : ROW_WIDTH_W;
  localparam int unsigned BW  = (PW > AREA_W) ? PW : AREA_W;
  localparam logic [AREA_W-1:0] AreaMax = {AREA_W{1'b1}};

  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [IW-1:0]          pos_q, col_q, top_q, clr_cnt_q;
  logic                   cell_q, last_q, drain_q, prod_vld_q, out_vld_q;
  logic [HW-1:0]          h_q, th_q;
  logic [CW1-1:0]         depth_q, hwm_q;
  logic [PW-1:0]          prod_q;
  logic [AREA_W-1:0]      best_q, out_area_q;

  logic [WW-1:0]     rw_x;
  logic [CW1-1:0]    eff_w, col_p1, left, right, span;
  logic [IW-1:0]     col_c;
  logic [HW-1:0]     rd_h, h_d;
  logic [IW-1:0]     rd_s;
  logic [PW-1:0]     prod_d;
  logic [BW-1:0]     prod_x;
  logic [AREA_W-1:0] capped;
  logic              h_we, s_we;
  logic [IW-1:0]     h_waddr, h_raddr;
  logic [HW-1:0]     h_wdata;

  always_comb begin
    rw_x = WW'(row_width_q);
    if (rw_x == '0) begin
      eff_w = CW1'(1);
    end else if (rw_x > WW'(MAX_COLS)) begin
      eff_w = CW1'(MAX_COLS);
    end else begin
      eff_w = CW1'(rw_x);
    end
  end

  assign col_c  = (CW1'(pos_q) >= eff_w) ? IW'(eff_w - CW1'(1)) : pos_q;
  assign col_p1 = CW1'(col_q) + CW1'(1);

  always_comb begin
    if (cell_q) begin
      h_d = (rd_h < HW'(MAX_ROWS)) ? rd_h + HW'(1) : HW'(MAX_ROWS);
    end else begin
      h_d = '0;
    end
  end

  assign h_we    = cmd_i.update || cmd_i.clear;
  assign h_waddr = cmd_i.clear ? clr_cnt_q : col_q;
  assign h_wdata = cmd_i.clear ? '0 : h_d;
  assign h_raddr = cmd_i.read_top ? top_q : col_c;

  mar_ram #(
    .DataW(HW),
    .Depth(MAX_COLS)
  ) u_heights (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(rd_h)
  );

  assign s_we = cmd_i.push && (depth_q < CW1'(MAX_COLS));

  mar_ram #(
    .DataW(IW),
    .Depth(MAX_COLS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(IW'(depth_q)),
    .wdata_i(col_q),
    .raddr_i(IW'(depth_q - CW1'(2))),
    .rdata_o(rd_s)
  );

  assign left   = (depth_q == '0) ? '0 : CW1'(rd_s) + CW1'(1);
  assign right  = drain_q ? col_p1 : CW1'(col_q);
  assign span   = (right > left) ? right - left : '0;
  assign prod_d = PW'(th_q) * PW'(span);

  assign prod_x = BW'(prod_q);
  assign capped = (prod_x > BW'(AreaMax)) ? AreaMax : AREA_W'(prod_x);

  assign sts_o.stack_empty = (depth_q == '0);
  assign sts_o.drain       = drain_q;
  assign sts_o.pop_cond    = drain_q || (rd_h > h_q);
  assign sts_o.row_ends    = last_q || (col_p1 >= eff_w);
  assign sts_o.last        = last_q;
  assign sts_o.out_busy    = out_vld_q && out_stall_i;
  assign sts_o.clear_done  = ((CW1'(clr_cnt_q) + CW1'(1)) >= hwm_q);

  assign out_valid_o = out_vld_q;
  assign max_area_o  = out_area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
      pos_q       <= '0;
      depth_q     <= '0;
      drain_q     <= 1'b0;
      prod_vld_q  <= 1'b0;
      best_q      <= '0;
      out_vld_q   <= 1'b0;
      hwm_q       <= CW1'(MAX_COLS);
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        row_width_q <= cfg_row_width_i;
      end
      prod_vld_q <= cmd_i.measure;
      if (prod_vld_q && (capped > best_q)) begin
        best_q <= capped;
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.accept) begin
        drain_q <= 1'b0;
      end
      if (cmd_i.update && (col_p1 > hwm_q)) begin
        hwm_q <= col_p1;
      end
      if (cmd_i.pop) begin
        depth_q <= depth_q - CW1'(1);
      end
      if (cmd_i.push) begin
        if (s_we) begin
          depth_q <= depth_q + CW1'(1);
        end
        drain_q <= sts_o.row_ends;
        pos_q   <= sts_o.row_ends ? '0 : IW'(col_p1);
      end
      if (cmd_i.emit) begin
        best_q    <= '0;
        clr_cnt_q <= '0;
      end
      if (cmd_i.clear) begin
        if (sts_o.clear_done) begin
          clr_cnt_q <= '0;
          hwm_q     <= '0;
        end else begin
          clr_cnt_q <= clr_cnt_q + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q  <= col_c;
      cell_q <= cell_req_i;
      last_q <= last_cell_i;
    end
    if (cmd_i.update) begin
      h_q <= h_d;
    end
    if (cmd_i.pop) begin
      th_q <= rd_h;
    end
    if (cmd_i.measure) begin
      prod_q <= prod_d;
      if (depth_q != '0) begin
        top_q <= rd_s;
      end
    end
    if (s_we) begin
      top_q <= col_q;
    end
    if (cmd_i.emit) begin
      out_area_q <= best_q;
    end
  end

endmodule

// File: design/mar_checker.sv
// Port-level checker of the rectangle block and its bind to the top level.
// Depends on mar_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mar_checker #(
  parameter int unsigned MAX_COLS = mar_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = mar_pkg::MAX_ROWS_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [mar_pkg::AREA_W-1:0] max_area_o
);

  import mar_pkg::*;

  localparam int unsigned AreaCap   = (1 << AREA_W) - 1;
  localparam int unsigned AreaFull  = MAX_COLS * MAX_ROWS;
  localparam int unsigned AreaBound = (AreaFull > AreaCap) ? AreaCap : AreaFull;

  `MAR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")
  `MAR_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(max_area_o), "stalled result changed")
  `MAR_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o, "request taken without busy cycle")
  `MAR_ASSERT(a_area_bound, !out_valid_o || (max_area_o <= AreaBound), "area beyond matrix size")

endmodule

bind maximal_all_ones_rectangle mar_checker #(
  .MAX_COLS(MAX_COLS),
  .MAX_ROWS(MAX_ROWS)
) u_mar_checker (.*);

// File: tb/sv/tb_maximal_all_ones_rectangle.sv
// Self-checking testbench of the largest all-ones rectangle block.
// Needs mar_pkg and maximal_all_ones_rectangle; areas of directed and random matrices
// under random stalls are checked by a built-in histogram-stack predictor or typed areas.
module tb_maximal_all_ones_rectangle;
  import mar_pkg::*;

  localparam int unsigned COLS       = MAX_COLS_DEF;
  localparam int unsigned ROWS       = MAX_ROWS_DEF;
  localparam int unsigned CIW        = $clog2(COLS);
  localparam int unsigned AREA_MAX   = (1 << AREA_W) - 1;
  localparam int unsigned SETTLE     = 5 + 3 * COLS + 1 + COLS + 32;
  localparam int unsigned RAND_ITEMS = 1100;
  localparam int unsigned LIMIT_TU   = 10_000_000;
  localparam int          NO_WRITE   = -1;

  typedef struct packed {
    int                set_w;
    int                reps;
    bit                bit_val;
    bit                last;
    bit                typed;
    logic [AREA_W-1:0] area;
  } cell_run_t;

  localparam int NUM_RUNS = 15;

  cell_run_t dir_runs [NUM_RUNS] = '{
    '{NO_WRITE, 1,   1'b0, 1'b1, 1'b1, 17'd0},
    '{NO_WRITE, 1,   1'b1, 1'b1, 1'b1, 17'd1},
    '{0,        3,   1'b1, 1'b1, 1'b1, 17'd3},
    '{1,        260, 1'b1, 1'b1, 1'b1, 17'd256},
    '{511,      4,   1'b1, 1'b1, 1'b1, 17'd4},
    '{4,        1,   1'b1, 1'b0, 1'b0, 17'd0},
    '{NO_WRITE, 1,   1'b0, 1'b0, 1'b0, 17'd0},
    '{NO_WRITE, 2,   1'b1, 1'b0, 1'b0, 17'd0},
    '{NO_WRITE, 4,   1'b1, 1'b1, 1'b0, 17'd0},
    '{8,        5,   1'b1, 1'b0, 1'b0, 17'd0},
    '{3,        4,   1'b1, 1'b1, 1'b0, 17'd0},
    '{6,        8,   1'b1, 1'b1, 1'b0, 17'd0},
    '{256,      256, 1'b1, 1'b0, 1'b0, 17'd0},
    '{NO_WRITE, 1,   1'b0, 1'b1, 1'b1, 17'd256},
    '{2,        4,   1'b0, 1'b1, 1'b1, 17'd0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [ROW_WIDTH_W-1:0] cfg_row_width_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   cell_req_i;
  logic                   last_cell_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [AREA_W-1:0]      max_area_o;

  int unsigned            col_height [COLS];
  int unsigned            col_stack [COLS];
  int unsigned            stk_depth;
  int unsigned            col_pos;
  int unsigned            best_area;
  logic [ROW_WIDTH_W-1:0] width_reg;

  logic [AREA_W-1:0]      area_q [$];
  int                     errors = 0;
  bit                     sender_calm = 1'b0;

  maximal_all_ones_rectangle uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_row_width_i(cfg_row_width_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cell_req_i     (cell_req_i),
    .last_cell_i    (last_cell_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .max_area_o     (max_area_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned eff_cols();
    int unsigned w;
    w = 32'(width_reg);
    if (w == 0) w = 1;
    if (w > COLS) w = COLS;
    return w;
  endfunction

  task automatic clear_rectangle_state();
    col_height = '{default: 0};
    col_stack  = '{default: 0};
    stk_depth  = 0;
    col_pos    = 0;
    best_area  = 0;
  endtask

  task automatic pop_bar(input int unsigned right);
    int unsigned top;
    int unsigned lft;
    int unsigned area;
    stk_depth = stk_depth - 1;
    top  = col_stack[CIW'(stk_depth)];
    lft  = (stk_depth == 0) ? 0 : col_stack[CIW'(stk_depth - 1)] + 1;
    area = (right > lft) ? col_height[CIW'(top)] * (right - lft) : 0;
    if (area > AREA_MAX) area = AREA_MAX;
    if (area > best_area) best_area = area;
  endtask

  task automatic track_rectangle(input bit c, input bit l, output bit emits,
                                 output logic [AREA_W-1:0] area);
    int unsigned w;
    int unsigned col;
    int unsigned h;
    w   = eff_cols();
    col = col_pos;
    if (col >= w) col = w - 1;
    h = col_height[CIW'(col)];
    if (c) h = (h < ROWS) ? h + 1 : ROWS;
    else h = 0;
    col_height[CIW'(col)] = h;
    while (stk_depth > 0 && col_height[CIW'(col_stack[CIW'(stk_depth - 1)])] > h) begin
      pop_bar(col);
    end
    if (stk_depth < COLS) begin
      col_stack[CIW'(stk_depth)] = col;
      stk_depth = stk_depth + 1;
    end
    if (l || col + 1 >= w) begin
      while (stk_depth > 0) pop_bar(col + 1);
      col_pos = 0;
    end else begin
      col_pos = col + 1;
    end
    emits = l;
    area  = AREA_W'(best_area);
    if (l) clear_rectangle_state();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (area_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_width(input int unsigned w);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_row_width_i <= ROW_WIDTH_W'(w);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    width_reg = ROW_WIDTH_W'(w);
  endtask

  task automatic send_cell(input bit c, input bit l, input bit use_typed,
                           input logic [AREA_W-1:0] typed_area);
    bit                emits;
    logic [AREA_W-1:0] area;
    int unsigned       gap;
    track_rectangle(c, l, emits, area);
    if (emits) area_q.push_back(use_typed ? typed_area : area);
    gap = sender_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cell_req_i  <= c;
    last_cell_i <= l;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      int unsigned n;
      n = idle_len();
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(50, 150)) @(posedge clk_i);
      else repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (area_q.size() == 0) begin
        $display("%0t: max_area expected none, got %0d", $time, max_area_o);
        errors++;
      end else begin
        if (max_area_o !== area_q[0]) begin
          $display("%0t: max_area expected %0d, got %0d", $time, area_q[0], max_area_o);
          errors++;
        end
        area_q.delete(0);
      end
    end
  end

  initial begin
    #(LIMIT_TU);
    $display("tb_maximal_all_ones_rectangle: FAIL");
    $finish;
  end

  initial begin
    int unsigned rand_items;
    int unsigned w;
    int unsigned ew;
    int unsigned rows;
    int unsigned full;
    int unsigned n;
    int unsigned density;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_row_width_i = '0;
    in_valid_i      = 1'b0;
    cell_req_i      = 1'b0;
    last_cell_i     = 1'b0;
    clear_rectangle_state();
    width_reg  = ROW_WIDTH_RST;
    rand_items = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NUM_RUNS; r++) begin
      if (dir_runs[r].set_w != NO_WRITE) set_width(dir_runs[r].set_w);
      for (int i = 0; i < dir_runs[r].reps; i++) begin
        send_cell(dir_runs[r].bit_val, dir_runs[r].last && i == dir_runs[r].reps - 1,
                  dir_runs[r].typed, dir_runs[r].area);
      end
    end

    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: w = $urandom_range(1, 6);
        5, 6:          w = $urandom_range(7, 16);
        7:             w = $urandom_range(17, 64);
        8:             w = ($urandom_range(0, 1) == 0) ? 0 : 256;
        default:       w = $urandom_range(257, 511);
      endcase
      set_width(w);
      ew = (w == 0) ? 1 : ((w > COLS) ? COLS : w);
      repeat ($urandom_range(1, 6)) begin
        rows = $urandom_range(1, (ew > 32) ? 1 : 6);
        full = ew * rows;
        if (ew > 32 && $urandom_range(0, 3) != 0) n = $urandom_range(1, 48);
        else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, full);
        else n = full;
        case ($urandom_range(0, 4))
          0:       density = 15;
          1:       density = 50;
          2:       density = 80;
          3:       density = 95;
          default: density = 100;
        endcase
        sender_calm = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++) begin
          send_cell($urandom_range(0, 99) < density, i == n - 1, 1'b0, '0);
        end
        rand_items += n;
        if ($urandom_range(0, 14) == 0) wait_drained();
      end
      sender_calm = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, (ew > 32) ? 20 : 2 * ew);
        for (int i = 0; i < n; i++) send_cell($urandom_range(0, 1) == 1, 1'b0, 1'b0, '0);
        rand_items += n;
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_maximal_all_ones_rectangle: PASS");
    end else begin
      $display("tb_maximal_all_ones_rectangle: FAIL");
    end
    $finish;
  end

endmodule
